### hw/rtl/vlcp_pkg.sv
// shared types and constants for the variable-length code packer
// no dependencies; imported by the interfaces and all packer modules
`timescale 1ns / 1ps

package vlcp_pkg;

   localparam int ACTION_W   = 2;
   localparam int SYMBOL_W   = 8;
   localparam int CODE_W     = 64;
   localparam int CODE_LEN_W = 7;
   localparam int BYTE_W     = 8;
   localparam int FILL_W     = 3;
   localparam int TAKE_W     = 4;

   // request actions, action code three is unused
   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

   // one step of the shared bit-append unit
   typedef struct packed {
      logic [BYTE_W-1:0] next_byte;
      logic [TAKE_W-1:0] take;
      logic [TAKE_W-1:0] next_fill;
      logic              full;
   } chunk_result_type;

endpackage

### hw/rtl/vlcp_req_if.sv
// request channel of the code packer: valid/ready plus one request word
// depends on vlcp_pkg
`timescale 1ns / 1ps

interface vlcp_req_if import vlcp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [SYMBOL_W-1:0]   symbol;
   logic [CODE_W-1:0]     code_bits;
   logic [CODE_LEN_W-1:0] code_length;

   modport source (output valid, action, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

### hw/rtl/vlcp_rsp_if.sv
// response channel of the code packer: valid/ready plus one packed byte word
// depends on vlcp_pkg
`timescale 1ns / 1ps

interface vlcp_rsp_if import vlcp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

### hw/rtl/vlcp_table.sv
// code and length tables: one write port, one registered read port
// depends on vlcp_pkg; length entries carry valid bits cleared by reset
`timescale 1ns / 1ps

module vlcp_table import vlcp_pkg::*; #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 64,
   localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1,
   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [SYM_W-1:0]        wr_addr,
   input  logic [MAX_CODE_LEN-1:0] wr_code,
   input  logic [LEN_W-1:0]        wr_len,
   input  logic                    rd_en,
   input  logic [SYM_W-1:0]        rd_addr,
   output logic [MAX_CODE_LEN-1:0] rd_code,
   output logic [LEN_W-1:0]        rd_len
);

   logic [MAX_CODE_LEN-1:0] code_mem_ff [SYMBOL_COUNT];
   logic [LEN_W-1:0]        len_mem_ff  [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] valid_ff;
   logic [SYMBOL_COUNT-1:0] valid_in;
   logic [MAX_CODE_LEN-1:0] rd_code_ff;
   logic [LEN_W-1:0]        rd_len_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem_ff[wr_addr] <= wr_code;
         len_mem_ff[wr_addr]  <= wr_len;
      end
   end

   // an entry never written reads as length zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_code_ff <= code_mem_ff[rd_addr];
         rd_len_ff  <= valid_ff[rd_addr] ? len_mem_ff[rd_addr] : '0;
      end
   end

   assign rd_code = rd_code_ff;
   assign rd_len  = rd_len_ff;

endmodule

### hw/rtl/vlcp_chunk_unit.sv
// shared bit-append unit: moves up to one byte's worth of code bits,
// msb first, into the pending byte; depends on vlcp_pkg
`timescale 1ns / 1ps

module vlcp_chunk_unit import vlcp_pkg::*; #(
   parameter int MAX_CODE_LEN = 64,
   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1)
) (
   input  logic [MAX_CODE_LEN-1:0] code,
   input  logic [LEN_W-1:0]        remaining,
   input  logic [FILL_W-1:0]       fill,
   input  logic [BYTE_W-1:0]       pending,
   output chunk_result_type        result
);

   logic [TAKE_W-1:0]       space;
   logic [TAKE_W-1:0]       take;
   logic [LEN_W-1:0]        shamt;
   logic [MAX_CODE_LEN-1:0] shifted;
   logic [BYTE_W:0]         mask;
   logic [BYTE_W-1:0]       chunk;
   logic [BYTE_W-1:0]       placed;
   logic [TAKE_W-1:0]       fill_sum;

   always_comb begin
      space    = TAKE_W'(BYTE_W) - {1'b0, fill};
      take     = (remaining < LEN_W'(space)) ? remaining[TAKE_W-1:0] : space;
      // next bits to send sit just below the remaining count
      shamt    = remaining - LEN_W'(take);
      shifted  = code >> shamt;
      mask     = ((BYTE_W + 1)'(1) << take) - (BYTE_W + 1)'(1);
      chunk    = shifted[BYTE_W-1:0] & mask[BYTE_W-1:0];
      placed   = chunk << (space - take);
      fill_sum = {1'b0, fill} + take;

      result.next_byte = pending | placed;
      result.take      = take;
      result.next_fill = fill_sum;
      result.full      = (fill_sum == TAKE_W'(BYTE_W));
   end

endmodule

### hw/rtl/variable_length_code_packer.sv
// variable-length code packer, per request word: load: written at once,
//   back to back; encode: registered table read, read state, then one
//   append step per byte boundary, at most 9 steps for a 64-bit code; ready is
//   low meanwhile and steps stall while a full byte waits at the output
//   flush: a last byte if bits are pending; reset (sync, active high) clears
//   the pending byte, fill count, length-table valid bits and the output
`timescale 1ns / 1ps

module variable_length_code_packer import vlcp_pkg::*; #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   vlcp_req_if.sink   req_chan,
   vlcp_rsp_if.source rsp_chan
);

   localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] pending_ff, pending_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic                    req_fire;
   logic                    sym_in_range;
   logic [SYM_W-1:0]        sym_index;
   logic [LEN_W-1:0]        load_len;
   logic                    tbl_wr_en;
   logic                    tbl_rd_en;
   logic [MAX_CODE_LEN-1:0] tbl_code;
   logic [LEN_W-1:0]        tbl_len;
   chunk_result_type        step;
   logic                    slot_free;
   logic                    step_ok;
   logic                    emit;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // symbols past the table act as unused
   assign sym_in_range = ({1'b0, req_chan.symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));
   assign sym_index    = req_chan.symbol[SYM_W-1:0];

   // long codes saturate; bits above the length are never read
   assign load_len = (req_chan.code_length > CODE_LEN_W'(MAX_CODE_LEN)) ?
                     LEN_W'(MAX_CODE_LEN) : req_chan.code_length[LEN_W-1:0];

   assign tbl_wr_en = req_fire && (req_chan.action == ACT_LOAD) && sym_in_range;
   assign tbl_rd_en = req_fire && (req_chan.action == ACT_ENCODE) && sym_in_range;

   vlcp_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (sym_index),
      .wr_code (req_chan.code_bits[MAX_CODE_LEN-1:0]),
      .wr_len  (load_len),
      .rd_en   (tbl_rd_en),
      .rd_addr (sym_index),
      .rd_code (tbl_code),
      .rd_len  (tbl_len)
   );

   // read data holds until the next encode, so the unit works on it directly
   vlcp_chunk_unit #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_chunk (
      .code      (tbl_code),
      .remaining (rem_ff),
      .fill      (fill_ff),
      .pending   (pending_ff),
      .result    (step)
   );

   // output register is free when empty or being drained this cycle
   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign step_ok   = !step.full || slot_free;

   always_comb begin
      state_in    = state_ff;
      pending_in  = pending_ff;
      fill_in     = fill_ff;
      rem_in      = rem_ff;
      emit        = 1'b0;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.action)
                  ACT_ENCODE: begin
                     if (sym_in_range) begin
                        state_in = ST_READ;
                     end
                  end
                  ACT_FLUSH: begin
                     if (fill_ff != '0) begin
                        state_in = ST_FLUSH;
                     end
                  end
                  default: begin
                     // loads finish in the table write, unused action is dropped
                  end
               endcase
            end
         end
         ST_READ: begin
            rem_in   = tbl_len;
            state_in = (tbl_len == '0) ? ST_IDLE : ST_RUN;
         end
         ST_RUN: begin
            if (step_ok) begin
               rem_in = rem_ff - LEN_W'(step.take);
               if (step.full) begin
                  emit        = 1'b1;
                  out_byte_in = step.next_byte;
                  // fewer than a byte left means this byte ends the word
                  out_last_in = (rem_in < LEN_W'(BYTE_W));
                  pending_in  = '0;
                  fill_in     = '0;
               end else begin
                  pending_in = step.next_byte;
                  fill_in    = step.next_fill[FILL_W-1:0];
               end
               if (rem_in == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               emit        = 1'b1;
               out_byte_in = pending_ff;
               out_last_in = 1'b1;
               pending_in  = '0;
               fill_in     = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = emit || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         fill_ff      <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         fill_ff      <= fill_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.last     = out_last_ff;

   // unfilled positions of the pending byte stay zero
   a_pending_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & (8'hFF >> fill_ff)) == '0)
      else $error("pending byte has bits past the fill point");

   // append steps only run with code bits left
   a_run_has_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (rem_ff != '0))
      else $error("append step with no code bits remaining");

   // every step that goes ahead consumes at least one bit
   a_run_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ok) |=> (rem_ff < $past(rem_ff)))
      else $error("append step made no progress");

   // an emitted byte leaves nothing pending
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> (fill_ff == '0 && pending_ff == '0 && out_valid_ff))
      else $error("pending bits survived an emitted byte");

endmodule
